### src/mpsm_pkg.sv
// Shared types and constants of the multi-pattern string matcher.
// Used by every module of the block but mpsm_ram; depends on nothing else.
`default_nettype none

package mpsm_pkg;

  localparam int ALPHABET_SIZE_DEF = 26;
  localparam int MAX_NODES_DEF     = 256;
  localparam int MAX_PATTERNS_DEF  = 16;

  localparam int CHAR_W     = 8;
  localparam int IDX_W      = 4;
  localparam int POS_W      = 32;
  localparam int RESULT_CAP = 16;
  localparam int NRES_W     = $clog2(RESULT_CAP);

  localparam logic [CHAR_W-1:0] FIRST_LETTER_RST = 8'd97;

  typedef enum logic [1:0] {
    CMD_CLEAR   = 2'd0,
    CMD_PATTERN = 2'd1,
    CMD_BUILD   = 2'd2,
    CMD_TEXT    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_MATCH   = 2'd0,
    KIND_DONE    = 2'd1,
    KIND_FULL    = 2'd2,
    KIND_BADCHAR = 2'd3
  } kind_e;

  typedef struct packed {
    cmd_e              cmd;
    logic [CHAR_W-1:0] character;
    logic              end_of_pattern;
    logic              start_of_text;
  } in_item_t;

  typedef struct packed {
    kind_e            kind;
    logic [IDX_W-1:0] pattern_index;
    logic [POS_W-1:0] start_position;
    logic             last_of_run;
  } result_t;

  // A request after the front end has mapped the character to a symbol.
  typedef struct packed {
    cmd_e              cmd;
    logic [CHAR_W-1:0] sym;
    logic              sym_ok;
    logic              eop;
    logic              sot;
  } cls_item_t;

  typedef struct packed {
    logic      valid;
    cls_item_t item;
  } cls_q_t;

endpackage

`default_nettype wire

### src/mpsm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; used for the child, mask, failure-link, output-link and queue tables.
`default_nettype none

module mpsm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### src/mpsm_front.sv
// Front end: accepts requests, maps characters to alphabet symbols and
// holds them in a two-entry queue for the engine. Uses mpsm_pkg.
`default_nettype none

module mpsm_front
  import mpsm_pkg::*;
#(
  parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire in_item_t          in_data_i,
  input  wire logic [CHAR_W-1:0] first_letter_i,
  output cls_q_t                 q_o,
  input  wire logic              q_pop_i
);

  cls_item_t  ent_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  cls_item_t  cls;
  logic       push;

  always_comb begin
    cls.cmd    = in_data_i.cmd;
    cls.sym    = in_data_i.character - first_letter_i;
    cls.sym_ok = {1'b0, cls.sym} < (CHAR_W+1)'(ALPHABET_SIZE);
    cls.eop    = in_data_i.end_of_pattern;
    cls.sot    = in_data_i.start_of_text;
  end

  assign in_ready_o = (cnt_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign q_o.valid  = (cnt_q != 2'd0);
  assign q_o.item   = ent_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wptr_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) begin
        wptr_q <= ~wptr_q;
      end
      if (q_pop_i) begin
        rptr_q <= ~rptr_q;
      end
      cnt_q <= cnt_q + 2'(push) - 2'(q_pop_i);
    end
  end

endmodule

`default_nettype wire

### src/mpsm_engine.sv
// Back end: table clear, trie insertion, breadth-first link build and text search.
// Uses mpsm_pkg and the tables held in mpsm_ram instances.
`default_nettype none

module mpsm_engine
  import mpsm_pkg::*;
#(
  parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF,
  parameter int MAX_NODES     = MAX_NODES_DEF,
  parameter int MAX_PATTERNS  = MAX_PATTERNS_DEF
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire cls_q_t q_i,
  output logic        q_pop_o,
  output logic        out_valid_o,
  input  wire logic   out_ready_i,
  output result_t     out_data_o
);

  localparam int NW  = $clog2(MAX_NODES);
  localparam int CD  = MAX_NODES * ALPHABET_SIZE;
  localparam int CAW = $clog2(CD);
  localparam int PIW = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;
  localparam int PCW = $clog2(MAX_PATTERNS + 1);

  typedef enum logic [20:0] {
    ST_SWEEP  = 21'd1 << 0,
    ST_IDLE   = 21'd1 << 1,
    ST_P_RD   = 21'd1 << 2,
    ST_P_CHK  = 21'd1 << 3,
    ST_P_MRD  = 21'd1 << 4,
    ST_P_MWR  = 21'd1 << 5,
    ST_T_RD   = 21'd1 << 6,
    ST_T_CHK  = 21'd1 << 7,
    ST_T_FL   = 21'd1 << 8,
    ST_M_RD   = 21'd1 << 9,
    ST_M_LD   = 21'd1 << 10,
    ST_M_EMIT = 21'd1 << 11,
    ST_B_CRD  = 21'd1 << 12,
    ST_B_CCHK = 21'd1 << 13,
    ST_B_FL   = 21'd1 << 14,
    ST_B_FCHK = 21'd1 << 15,
    ST_B_FSET = 21'd1 << 16,
    ST_B_POP  = 21'd1 << 17,
    ST_B_PW   = 21'd1 << 18,
    ST_EMIT1  = 21'd1 << 19,
    ST_SPARE  = 21'd1 << 20
  } state_e;

  state_e state_q, state_d;

  cls_item_t              item_q, item_d;
  logic [NW-1:0]          node_q, node_d;
  logic [POS_W-1:0]       pos_q, pos_d, pos_item_q, pos_item_d;
  logic [NW-1:0]          ins_node_q, ins_node_d, ins_len_q, ins_len_d;
  logic                   discard_q, discard_d;
  logic [NW-1:0]          ncount_q, ncount_d;
  logic [PCW-1:0]         pcount_q, pcount_d;
  logic [NW-1:0]          cur_q, cur_d, v_q, v_d, f_q, f_d, olink_q, olink_d;
  logic [CHAR_W-1:0]      ch_q, ch_d;
  logic                   root_q, root_d;
  logic [NW-1:0]          head_q, head_d, tail_q, tail_d;
  logic [CAW-1:0]         sweep_q, sweep_d;
  logic [MAX_PATTERNS-1:0] mask_q, mask_d;
  logic [NRES_W-1:0]      nres_q, nres_d;
  kind_e                  kind_q, kind_d;
  logic [NW-1:0]          plen_q [MAX_PATTERNS];
  logic                   plen_we;
  result_t                out_q, out_d;
  logic                   out_valid_q, out_valid_d, out_free;

  logic                    ct_we;
  logic [CAW-1:0]          ct_waddr, ct_raddr;
  logic [NW-1:0]           ct_wdata, ct_rdata;
  logic                    mk_we;
  logic [NW-1:0]           mk_waddr, mk_raddr;
  logic [MAX_PATTERNS-1:0] mk_wdata, mk_rdata;
  logic                    fl_we, ol_we, bq_we;
  logic [NW-1:0]           fl_waddr, fl_wdata, fl_raddr, fl_rdata;
  logic [NW-1:0]           ol_waddr, ol_wdata, ol_raddr, ol_rdata;
  logic [NW-1:0]           bq_waddr, bq_wdata, bq_raddr, bq_rdata;

  logic [PIW-1:0]          low_idx;
  logic [MAX_PATTERNS-1:0] rest_mask;
  logic                    is_last, new_node, ch_end;
  logic [NW-1:0]           child;

  function automatic logic [CAW-1:0] caddr(input logic [NW-1:0] n,
                                           input logic [CHAR_W-1:0] s);
    caddr = CAW'(n) * CAW'(ALPHABET_SIZE) + CAW'(s);
  endfunction

  function automatic logic [PIW-1:0] lowest(input logic [MAX_PATTERNS-1:0] m);
    lowest = '0;
    for (int i = MAX_PATTERNS - 1; i >= 0; i--) begin
      if (m[i]) begin
        lowest = PIW'(i);
      end
    end
  endfunction

  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign low_idx     = lowest(mask_q);
  assign rest_mask   = mask_q & ~(MAX_PATTERNS'(1) << low_idx);
  assign is_last     = (nres_q == NRES_W'(RESULT_CAP - 1)) ||
                       ((rest_mask == '0) && (olink_q == '0));
  assign ch_end      = ({1'b0, ch_q} == (CHAR_W+1)'(ALPHABET_SIZE - 1));
  assign new_node    = (ct_rdata == '0);
  assign child       = new_node ? ncount_q + NW'(1) : ct_rdata;

  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    node_d      = node_q;
    pos_d       = pos_q;
    pos_item_d  = pos_item_q;
    ins_node_d  = ins_node_q;
    ins_len_d   = ins_len_q;
    discard_d   = discard_q;
    ncount_d    = ncount_q;
    pcount_d    = pcount_q;
    cur_d       = cur_q;
    v_d         = v_q;
    f_d         = f_q;
    olink_d     = olink_q;
    ch_d        = ch_q;
    root_d      = root_q;
    head_d      = head_q;
    tail_d      = tail_q;
    sweep_d     = sweep_q;
    mask_d      = mask_q;
    nres_d      = nres_q;
    kind_d      = kind_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    plen_we     = 1'b0;
    q_pop_o     = 1'b0;

    ct_we = 1'b0; ct_waddr = '0; ct_wdata = '0; ct_raddr = '0;
    mk_we = 1'b0; mk_waddr = '0; mk_wdata = '0; mk_raddr = '0;
    fl_we = 1'b0; fl_waddr = '0; fl_wdata = '0; fl_raddr = '0;
    ol_we = 1'b0; ol_waddr = '0; ol_wdata = '0; ol_raddr = '0;
    bq_we = 1'b0; bq_waddr = tail_q; bq_wdata = '0; bq_raddr = head_q;

    unique case (state_q)
      ST_SWEEP: begin
        ct_we    = 1'b1;
        ct_waddr = sweep_q;
        if (32'(sweep_q) < 32'(MAX_NODES)) begin
          mk_we    = 1'b1;
          mk_waddr = sweep_q[NW-1:0];
          fl_we    = 1'b1;
          fl_waddr = sweep_q[NW-1:0];
          ol_we    = 1'b1;
          ol_waddr = sweep_q[NW-1:0];
        end
        if (sweep_q == CAW'(CD - 1)) begin
          state_d = ST_IDLE;
        end else begin
          sweep_d = sweep_q + CAW'(1);
        end
      end

      ST_IDLE: begin
        if (q_i.valid) begin
          q_pop_o = 1'b1;
          item_d  = q_i.item;
          unique case (q_i.item.cmd)
            CMD_CLEAR: begin
              ncount_d   = '0;
              pcount_d   = '0;
              ins_node_d = '0;
              ins_len_d  = '0;
              discard_d  = 1'b0;
              node_d     = '0;
              sweep_d    = '0;
              state_d    = ST_SWEEP;
            end
            CMD_PATTERN: begin
              if (discard_q) begin
                if (q_i.item.eop) begin
                  discard_d = 1'b0;
                end
              end else if (!q_i.item.sym_ok) begin
                ins_node_d = '0;
                ins_len_d  = '0;
                discard_d  = !q_i.item.eop;
                kind_d     = KIND_BADCHAR;
                state_d    = ST_EMIT1;
              end else begin
                state_d = ST_P_RD;
              end
            end
            CMD_BUILD: begin
              fl_we   = 1'b1;
              ol_we   = 1'b1;
              cur_d   = '0;
              root_d  = 1'b1;
              ch_d    = '0;
              head_d  = '0;
              tail_d  = '0;
              state_d = ST_B_CRD;
            end
            CMD_TEXT: begin
              pos_item_d = q_i.item.sot ? '0 : pos_q;
              pos_d      = (q_i.item.sot ? '0 : pos_q) + POS_W'(1);
              if (!q_i.item.sym_ok) begin
                node_d  = '0;
                kind_d  = KIND_BADCHAR;
                state_d = ST_EMIT1;
              end else begin
                cur_d   = q_i.item.sot ? '0 : node_q;
                state_d = ST_T_RD;
              end
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end

      ST_P_RD: begin
        ct_raddr = caddr(ins_node_q, item_q.sym);
        state_d  = ST_P_CHK;
      end

      ST_P_CHK: begin
        if (new_node && ((NW+1)'(ncount_q) + (NW+1)'(1) >= (NW+1)'(MAX_NODES))) begin
          ins_node_d = '0;
          ins_len_d  = '0;
          discard_d  = !item_q.eop;
          kind_d     = KIND_FULL;
          state_d    = ST_EMIT1;
        end else begin
          if (new_node) begin
            ncount_d = child;
            ct_we    = 1'b1;
            ct_waddr = caddr(ins_node_q, item_q.sym);
            ct_wdata = child;
            fl_we    = 1'b1;
            fl_waddr = child;
            ol_we    = 1'b1;
            ol_waddr = child;
          end
          ins_node_d = child;
          ins_len_d  = ins_len_q + NW'(1);
          if (!item_q.eop) begin
            state_d = ST_IDLE;
          end else if (pcount_q >= PCW'(MAX_PATTERNS)) begin
            ins_node_d = '0;
            ins_len_d  = '0;
            discard_d  = 1'b0;
            kind_d     = KIND_FULL;
            state_d    = ST_EMIT1;
          end else begin
            state_d = ST_P_MRD;
          end
        end
      end

      ST_P_MRD: begin
        mk_raddr = ins_node_q;
        state_d  = ST_P_MWR;
      end

      ST_P_MWR: begin
        mk_we      = 1'b1;
        mk_waddr   = ins_node_q;
        mk_wdata   = mk_rdata | (MAX_PATTERNS'(1) << pcount_q);
        plen_we    = 1'b1;
        pcount_d   = pcount_q + PCW'(1);
        ins_node_d = '0;
        ins_len_d  = '0;
        state_d    = ST_IDLE;
      end

      ST_T_RD: begin
        ct_raddr = caddr(cur_q, item_q.sym);
        state_d  = ST_T_CHK;
      end

      ST_T_CHK: begin
        if (!new_node || cur_q == '0) begin
          node_d = ct_rdata;
          cur_d  = ct_rdata;
          nres_d = '0;
          state_d = (ct_rdata == '0) ? ST_IDLE : ST_M_RD;
        end else begin
          fl_raddr = cur_q;
          state_d  = ST_T_FL;
        end
      end

      ST_T_FL: begin
        cur_d    = fl_rdata;
        ct_raddr = caddr(fl_rdata, item_q.sym);
        state_d  = ST_T_CHK;
      end

      ST_M_RD: begin
        mk_raddr = cur_q;
        ol_raddr = cur_q;
        state_d  = ST_M_LD;
      end

      ST_M_LD: begin
        mask_d  = mk_rdata;
        olink_d = ol_rdata;
        state_d = ST_M_EMIT;
      end

      ST_M_EMIT: begin
        if (mask_q == '0) begin
          if (olink_q == '0) begin
            state_d = ST_IDLE;
          end else begin
            cur_d   = olink_q;
            state_d = ST_M_RD;
          end
        end else if (out_free) begin
          out_valid_d          = 1'b1;
          out_d.kind           = KIND_MATCH;
          out_d.pattern_index  = IDX_W'(low_idx);
          out_d.start_position = pos_item_q - POS_W'(plen_q[low_idx]) + POS_W'(1);
          out_d.last_of_run    = is_last;
          mask_d               = rest_mask;
          nres_d               = nres_q + NRES_W'(1);
          if (is_last) begin
            state_d = ST_IDLE;
          end
        end
      end

      ST_B_CRD: begin
        ct_raddr = caddr(cur_q, ch_q);
        state_d  = ST_B_CCHK;
      end

      ST_B_CCHK: begin
        if (new_node) begin
          state_d = ch_end ? ST_B_POP : ST_B_CRD;
          ch_d    = ch_q + CHAR_W'(1);
        end else if (root_q) begin
          // Children of the root fail back to the root.
          fl_we    = 1'b1;
          fl_waddr = ct_rdata;
          ol_we    = 1'b1;
          ol_waddr = ct_rdata;
          bq_we    = 1'b1;
          bq_wdata = ct_rdata;
          tail_d   = tail_q + NW'(1);
          state_d  = ch_end ? ST_B_POP : ST_B_CRD;
          ch_d     = ch_q + CHAR_W'(1);
        end else begin
          v_d      = ct_rdata;
          fl_raddr = cur_q;
          state_d  = ST_B_FL;
        end
      end

      ST_B_FL: begin
        f_d      = fl_rdata;
        ct_raddr = caddr(fl_rdata, ch_q);
        state_d  = ST_B_FCHK;
      end

      ST_B_FCHK: begin
        if (f_q != '0 && new_node) begin
          fl_raddr = f_q;
          state_d  = ST_B_FL;
        end else begin
          f_d      = ct_rdata;
          mk_raddr = ct_rdata;
          ol_raddr = ct_rdata;
          state_d  = ST_B_FSET;
        end
      end

      ST_B_FSET: begin
        fl_we    = 1'b1;
        fl_waddr = v_q;
        fl_wdata = f_q;
        ol_we    = 1'b1;
        ol_waddr = v_q;
        ol_wdata = (mk_rdata != '0) ? f_q : ol_rdata;
        bq_we    = 1'b1;
        bq_wdata = v_q;
        tail_d   = tail_q + NW'(1);
        state_d  = ch_end ? ST_B_POP : ST_B_CRD;
        ch_d     = ch_q + CHAR_W'(1);
      end

      ST_B_POP: begin
        if (head_q == tail_q) begin
          kind_d  = KIND_DONE;
          state_d = ST_EMIT1;
        end else begin
          head_d  = head_q + NW'(1);
          state_d = ST_B_PW;
        end
      end

      ST_B_PW: begin
        cur_d   = bq_rdata;
        root_d  = 1'b0;
        ch_d    = '0;
        state_d = ST_B_CRD;
      end

      ST_EMIT1: begin
        if (out_free) begin
          out_valid_d          = 1'b1;
          out_d.kind           = kind_q;
          out_d.pattern_index  = '0;
          out_d.start_position = '0;
          out_d.last_of_run    = 1'b1;
          state_d              = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_SWEEP;
      sweep_q     <= '0;
      node_q      <= '0;
      pos_q       <= '0;
      ins_node_q  <= '0;
      ins_len_q   <= '0;
      discard_q   <= 1'b0;
      ncount_q    <= '0;
      pcount_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sweep_q     <= sweep_d;
      node_q      <= node_d;
      pos_q       <= pos_d;
      ins_node_q  <= ins_node_d;
      ins_len_q   <= ins_len_d;
      discard_q   <= discard_d;
      ncount_q    <= ncount_d;
      pcount_q    <= pcount_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    pos_item_q <= pos_item_d;
    cur_q      <= cur_d;
    v_q        <= v_d;
    f_q        <= f_d;
    olink_q    <= olink_d;
    ch_q       <= ch_d;
    root_q     <= root_d;
    head_q     <= head_d;
    tail_q     <= tail_d;
    mask_q     <= mask_d;
    nres_q     <= nres_d;
    kind_q     <= kind_d;
    out_q      <= out_d;
    if (plen_we) begin
      plen_q[pcount_q[PIW-1:0]] <= ins_len_q;
    end
  end

  mpsm_ram #(.WIDTH(NW), .DEPTH(CD)) u_child (
    .clk_i, .we_i(ct_we), .waddr_i(ct_waddr), .wdata_i(ct_wdata),
    .raddr_i(ct_raddr), .rdata_o(ct_rdata)
  );

  mpsm_ram #(.WIDTH(MAX_PATTERNS), .DEPTH(MAX_NODES)) u_mask (
    .clk_i, .we_i(mk_we), .waddr_i(mk_waddr), .wdata_i(mk_wdata),
    .raddr_i(mk_raddr), .rdata_o(mk_rdata)
  );

  mpsm_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_fail (
    .clk_i, .we_i(fl_we), .waddr_i(fl_waddr), .wdata_i(fl_wdata),
    .raddr_i(fl_raddr), .rdata_o(fl_rdata)
  );

  mpsm_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_olink (
    .clk_i, .we_i(ol_we), .waddr_i(ol_waddr), .wdata_i(ol_wdata),
    .raddr_i(ol_raddr), .rdata_o(ol_rdata)
  );

  mpsm_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_queue (
    .clk_i, .we_i(bq_we), .waddr_i(bq_waddr), .wdata_i(bq_wdata),
    .raddr_i(bq_raddr), .rdata_o(bq_rdata)
  );

endmodule

`default_nettype wire

### src/multi_pattern_string_matcher_core.sv
// Aho-Corasick multi-pattern matcher, top level.
// Depends on mpsm_pkg, mpsm_front, mpsm_engine and mpsm_ram.
//
// Requests enter on in_valid_i/in_ready_o as in_item_t: clear, pattern
// character, build, or text character. Results leave on out_valid_o/
// out_ready_i as result_t; each request yields zero or more results and
// the last one carries last_of_run. cfg_we_i/cfg_wdata_i write the code of
// alphabet symbol zero (97 after reset).
// A two-entry queue decouples the front end from the engine, so requests
// are taken while a result waits in the output register.
// The engine steps through its states for each request: a pattern
// character reads the child table, may add a node and, at the end of a
// pattern, sets its bit in the mask table; a text character follows
// failure links until a child is found, then walks the output chain and
// emits each match; build visits every child slot of the root and of
// every queued node and follows failure links for non-root children;
// clear sweeps the MAX_NODES*ALPHABET_SIZE child-table entries, one per cycle.
// The same sweep runs after reset; the front queue takes up to two
// requests meanwhile, and the engine starts on them when the sweep ends.
// A stalled receiver holds the engine at its next result; the front
// queue then fills and in_ready_o drops.
`default_nettype none

module multi_pattern_string_matcher_core
  import mpsm_pkg::*;
#(
  parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF,
  parameter int MAX_NODES     = MAX_NODES_DEF,
  parameter int MAX_PATTERNS  = MAX_PATTERNS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [CHAR_W-1:0] cfg_wdata_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire in_item_t          in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output result_t                out_data_o
);

  logic [CHAR_W-1:0] first_letter_q;
  cls_q_t            cls_q;
  logic              q_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_letter_q <= FIRST_LETTER_RST;
    end else if (cfg_we_i) begin
      first_letter_q <= cfg_wdata_i;
    end
  end

  mpsm_front #(.ALPHABET_SIZE(ALPHABET_SIZE)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .first_letter_i(first_letter_q), .q_o(cls_q), .q_pop_i(q_pop)
  );

  mpsm_engine #(
    .ALPHABET_SIZE(ALPHABET_SIZE),
    .MAX_NODES(MAX_NODES),
    .MAX_PATTERNS(MAX_PATTERNS)
  ) u_engine (
    .clk_i, .rst_ni, .q_i(cls_q), .q_pop_o(q_pop),
    .out_valid_o, .out_ready_i, .out_data_o
  );

  // The engine only takes a request that the queue actually holds.
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> cls_q.valid) else $error("engine popped an empty queue");

  // Status results stand alone, so they always end their run.
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.kind != KIND_MATCH) |-> out_data_o.last_of_run)
    else $error("status result without last_of_run");

  a_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.kind != KIND_MATCH) |->
      (out_data_o.pattern_index == '0 && out_data_o.start_position == '0))
    else $error("status result carries match fields");

  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.kind == KIND_MATCH) |->
      (32'(out_data_o.pattern_index) < MAX_PATTERNS))
    else $error("match reports a pattern index never assigned");

endmodule

`default_nettype wire

### test/testbench.sv
// Self-checking testbench of the multi-pattern string matcher core.
// Depends on mpsm_pkg and multi_pattern_string_matcher_core.
// A predictor of trie, links and text walk, or a typed row, checks each result.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import mpsm_pkg::*;

  localparam int NSYM      = 26;
  localparam int NNODE     = 256;
  localparam int NPAT      = 16;
  localparam int WD_LIMIT  = 40000;
  localparam int SETTLE    = 7000;
  localparam int RAND_GOAL = 195;

  typedef struct {
    in_item_t it;
    bit       typed;
    result_t  res;
  } dir_row_t;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     cfg_we = 1'b0;
  logic [7:0] cfg_wdata = '0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  in_item_t in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  result_t  out_data;

  multi_pattern_string_matcher_core i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // Predictor state.
  bit [7:0]  child [NNODE*NSYM];
  bit [7:0]  fail_lnk [NNODE];
  bit [7:0]  out_lnk [NNODE];
  bit [15:0] pat_mask [NNODE];
  int        pat_len [NPAT];
  int        node_cnt, pat_cnt, ins_node, ins_len, scan_node;
  bit [31:0] text_pos;
  bit        skip_rest;
  bit [7:0]  sym_base = FIRST_LETTER_RST;

  result_t   match_q[$];
  result_t   fresh_q[$];
  bit        typed_q[$];
  result_t   typed_res_q[$];

  int errors = 0;
  int n_checked = 0;
  int n_sent = 0;
  int n_matches = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  int rand_items = 0;

  function automatic result_t mk_res(kind_e k, bit [3:0] idx, bit [31:0] pos, bit last);
    result_t r;
    r.kind = k;
    r.pattern_index = idx;
    r.start_position = pos;
    r.last_of_run = last;
    return r;
  endfunction

  function automatic void clear_trie();
    foreach (child[i]) child[i] = '0;
    foreach (fail_lnk[i]) begin
      fail_lnk[i] = '0;
      out_lnk[i] = '0;
      pat_mask[i] = '0;
    end
    node_cnt = 0;
    pat_cnt = 0;
    ins_node = 0;
    ins_len = 0;
    skip_rest = 1'b0;
    scan_node = 0;
  endfunction

  function automatic void refuse(kind_e k, bit eop);
    ins_node = 0;
    ins_len = 0;
    skip_rest = !eop;
    fresh_q.insert(fresh_q.size(), mk_res(k, '0, '0, 1'b1));
  endfunction

  function automatic void add_pattern_char(int sym, bit ok, bit eop);
    int slot, c;
    if (skip_rest) begin
      if (eop) skip_rest = 1'b0;
      return;
    end
    if (!ok) begin
      refuse(KIND_BADCHAR, eop);
      return;
    end
    slot = ins_node * NSYM + sym;
    c = child[slot];
    if (c == 0) begin
      if (node_cnt + 1 >= NNODE) begin
        refuse(KIND_FULL, eop);
        return;
      end
      node_cnt++;
      c = node_cnt;
      child[slot] = c[7:0];
      fail_lnk[c] = '0;
      out_lnk[c] = '0;
    end
    ins_node = c;
    ins_len++;
    if (eop) begin
      if (pat_cnt >= NPAT) begin
        refuse(KIND_FULL, 1'b1);
        return;
      end
      pat_mask[ins_node][pat_cnt] = 1'b1;
      pat_len[pat_cnt] = ins_len;
      pat_cnt++;
      ins_node = 0;
      ins_len = 0;
    end
  endfunction

  function automatic void build_links();
    int bfs[$];
    int node, v, f, steps;
    fail_lnk[0] = '0;
    out_lnk[0] = '0;
    for (int ch = 0; ch < NSYM; ch++) begin
      v = child[ch];
      if (v != 0) begin
        fail_lnk[v] = '0;
        out_lnk[v] = '0;
        bfs.insert(bfs.size(), v);
      end
    end
    while (bfs.size() > 0) begin
      node = bfs.pop_front();
      for (int ch = 0; ch < NSYM; ch++) begin
        v = child[node*NSYM + ch];
        if (v == 0) continue;
        f = fail_lnk[node];
        steps = 0;
        while (f > 0 && child[f*NSYM + ch] == 0 && steps < NNODE) begin
          f = fail_lnk[f];
          steps++;
        end
        f = child[f*NSYM + ch];
        fail_lnk[v] = f[7:0];
        out_lnk[v] = (pat_mask[f] != 0) ? f[7:0] : out_lnk[f];
        bfs.insert(bfs.size(), v);
      end
    end
    fresh_q.insert(fresh_q.size(), mk_res(KIND_DONE, '0, '0, 1'b1));
  endfunction

  function automatic void scan_text_char(int sym, bit ok, bit sot);
    bit [31:0] pos;
    int node, aux, steps, n;
    if (sot) begin
      scan_node = 0;
      text_pos = '0;
    end
    pos = text_pos;
    text_pos = text_pos + 1;
    if (!ok) begin
      scan_node = 0;
      fresh_q.insert(fresh_q.size(), mk_res(KIND_BADCHAR, '0, '0, 1'b1));
      return;
    end
    node = scan_node;
    steps = 0;
    while (node > 0 && child[node*NSYM + sym] == 0 && steps < NNODE) begin
      node = fail_lnk[node];
      steps++;
    end
    node = child[node*NSYM + sym];
    scan_node = node;
    aux = node;
    steps = 0;
    n = 0;
    while (aux != 0 && steps < NNODE && n < RESULT_CAP) begin
      for (int i = 0; i < NPAT && n < RESULT_CAP; i++) begin
        if (pat_mask[aux][i]) begin
          fresh_q.insert(fresh_q.size(),
                         mk_res(KIND_MATCH, i[3:0], pos - pat_len[i] + 1, 1'b0));
          n++;
        end
      end
      aux = out_lnk[aux];
      steps++;
    end
    if (n > 0) fresh_q[n-1].last_of_run = 1'b1;
  endfunction

  function automatic void predict(in_item_t it);
    bit [7:0] sym;
    bit ok;
    sym = it.character - sym_base;
    ok = (sym < NSYM);
    fresh_q.delete();
    case (it.cmd)
      CMD_CLEAR:   clear_trie();
      CMD_PATTERN: add_pattern_char(sym, ok, it.end_of_pattern);
      CMD_BUILD:   build_links();
      default:     scan_text_char(sym, ok, it.start_of_text);
    endcase
  endfunction

  initial begin
    clear_trie();
    text_pos = '0;
  end

  // Request and result monitors, plus the watchdog.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready) begin
        predict(in_data);
        if (typed_q.pop_front()) begin
          match_q.insert(match_q.size(), typed_res_q.pop_front());
        end else begin
          void'(typed_res_q.pop_front());
          foreach (fresh_q[i]) match_q.insert(match_q.size(), fresh_q[i]);
        end
      end
      if (out_valid && out_ready) begin
        n_checked++;
        if (out_data.kind == KIND_MATCH) n_matches++;
        if (match_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("ERROR: unexpected result kind=%0d idx=%0d pos=%0d last=%0b",
                     out_data.kind, out_data.pattern_index, out_data.start_position,
                     out_data.last_of_run);
        end else if (out_data !== match_q[0]) begin
          errors++;
          if (errors <= 10)
            $display("ERROR: result %0d: kind %0d/%0d idx %0d/%0d pos %0d/%0d last %0b/%0b",
                     n_checked, out_data.kind, match_q[0].kind, out_data.pattern_index,
                     match_q[0].pattern_index, out_data.start_position,
                     match_q[0].start_position, out_data.last_of_run,
                     match_q[0].last_of_run);
          void'(match_q.pop_front());
        end else begin
          void'(match_q.pop_front());
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WD_LIMIT) begin
        $display("Timeout: no request or result moved for %0d cycles", WD_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // The receiver stalls by a repeating eight-bit pattern, redrawn at random.
  int rx_cycle = 0;
  bit [7:0] rx_pattern = 8'hff;
  always @(posedge clk_i) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle % 150 == 0) begin
      case ($urandom_range(0, 3))
        0: rx_pattern <= 8'hff;
        1: rx_pattern <= 8'h01;
        default: rx_pattern <= 8'($urandom());
      endcase
    end
    out_ready <= rx_pattern[rx_cycle % 8];
  end

  task automatic send(in_item_t it, bit typed, result_t res);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
    typed_q.insert(typed_q.size(), typed);
    typed_res_q.insert(typed_res_q.size(), res);
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk_i); while (!in_ready);
    burst_left--;
    n_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (match_q.size() != 0) @(posedge clk_i);
  endtask

  // A clear gives no result, so the idle time after the drain covers its sweep.
  task automatic settle();
    drain();
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_base(bit [7:0] v);
    settle();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    sym_base = v;
  endtask

  function automatic in_item_t mk_item(cmd_e c, bit [7:0] chr, bit eop, bit sot);
    in_item_t it;
    it.cmd = c;
    it.character = chr;
    it.end_of_pattern = eop;
    it.start_of_text = sot;
    return it;
  endfunction

  task automatic send_rand(cmd_e c, bit [7:0] chr, bit eop, bit sot);
    send(mk_item(c, chr, eop, sot), 1'b0, '0);
    rand_items++;
  endtask

  function automatic bit [7:0] letter(int k);
    return sym_base + 8'($urandom_range(0, k - 1));
  endfunction

  dir_row_t dir_rows[$];

  task automatic row(cmd_e c, bit [7:0] chr, bit eop, bit sot, bit typed, result_t res);
    dir_row_t r;
    r.it = mk_item(c, chr, eop, sot);
    r.typed = typed;
    r.res = res;
    dir_rows.insert(dir_rows.size(), r);
  endtask

  initial begin
    result_t none, bad, done;
    bit [7:0] bases[$];
    bit did_table_fill;
    int k, len;
    none = '0;
    bad = mk_res(KIND_BADCHAR, '0, '0, 1'b1);
    done = mk_res(KIND_DONE, '0, '0, 1'b1);
    did_table_fill = 1'b0;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part with the reset alphabet starting at 'a'.
    row(CMD_TEXT, "a", 1'b0, 1'b1, 1'b0, none);
    row(CMD_TEXT, "{", 1'b1, 1'b0, 1'b1, bad);
    row(CMD_BUILD, 8'h00, 1'b0, 1'b0, 1'b1, done);
    row(CMD_PATTERN, "h", 1'b0, 1'b1, 1'b0, none);
    row(CMD_PATTERN, "e", 1'b1, 1'b0, 1'b0, none);
    row(CMD_PATTERN, "s", 1'b0, 1'b0, 1'b0, none);
    row(CMD_PATTERN, "h", 1'b0, 1'b0, 1'b0, none);
    row(CMD_PATTERN, "e", 1'b1, 1'b0, 1'b0, none);
    row(CMD_PATTERN, "h", 1'b0, 1'b0, 1'b0, none);
    row(CMD_PATTERN, "e", 1'b0, 1'b0, 1'b0, none);
    row(CMD_PATTERN, "r", 1'b0, 1'b0, 1'b0, none);
    row(CMD_PATTERN, "s", 1'b1, 1'b0, 1'b0, none);
    row(CMD_PATTERN, "A", 1'b0, 1'b0, 1'b1, bad);
    row(CMD_PATTERN, "b", 1'b1, 1'b0, 1'b0, none);
    row(CMD_PATTERN, "z", 1'b1, 1'b0, 1'b0, none);
    row(CMD_BUILD, 8'hff, 1'b1, 1'b1, 1'b1, done);
    row(CMD_TEXT, "u", 1'b0, 1'b1, 1'b0, none);
    row(CMD_TEXT, "s", 1'b0, 1'b0, 1'b0, none);
    row(CMD_TEXT, "h", 1'b0, 1'b0, 1'b0, none);
    row(CMD_TEXT, "e", 1'b0, 1'b0, 1'b0, none);
    row(CMD_TEXT, "r", 1'b0, 1'b0, 1'b0, none);
    row(CMD_TEXT, "s", 1'b0, 1'b0, 1'b0, none);
    row(CMD_TEXT, "z", 1'b0, 1'b0, 1'b0, none);
    row(CMD_CLEAR, 8'h5a, 1'b1, 1'b1, 1'b0, none);
    row(CMD_TEXT, "h", 1'b0, 1'b0, 1'b0, none);
    foreach (dir_rows[i]) send(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].res);

    // Random part: several alphabet origins, the wrapping ones among them.
    bases = '{8'd97, 8'd0, 8'd255, 8'd230, 8'($urandom())};
    foreach (bases[b]) begin
      write_base(bases[b]);
      send_rand(CMD_CLEAR, 8'($urandom()), 1'($urandom()), 1'($urandom()));
      for (int rnd = 0; rnd < 1 || rand_items < RAND_GOAL * (b + 1) / bases.size(); rnd++) begin
        k = $urandom_range(2, 4);
        if (b == 2 && !did_table_fill) begin
          // One-letter patterns overrun the pattern table; the last one is refused.
          did_table_fill = 1'b1;
          send_rand(CMD_CLEAR, 8'($urandom()), 1'b0, 1'b0);
          for (int i = 0; i <= NPAT; i++)
            send_rand(CMD_PATTERN, letter(2), 1'b1, 1'($urandom()));
          k = 2;
        end else begin
          if ($urandom_range(0, 2) == 0 || node_cnt > 200)
            send_rand(CMD_CLEAR, 8'($urandom()), 1'($urandom()), 1'($urandom()));
          repeat ($urandom_range(1, 6)) begin
            len = $urandom_range(1, 4);
            for (int i = 0; i < len; i++)
              send_rand(CMD_PATTERN,
                        ($urandom_range(0, 19) == 0) ? 8'($urandom()) : letter(k),
                        (i == len - 1), 1'($urandom()));
          end
        end
        send_rand(CMD_BUILD, 8'($urandom()), 1'($urandom()), 1'($urandom()));
        if ($urandom_range(0, 9) == 0) drain();
        repeat ($urandom_range(10, 30))
          send_rand(CMD_TEXT,
                    ($urandom_range(0, 14) == 0) ? 8'($urandom()) : letter(k),
                    1'($urandom()), ($urandom_range(0, 19) == 0));
      end
    end

    settle();
    $display("Sent %0d requests under %0d alphabet origins; %0d results checked, %0d matches.",
             n_sent, bases.size(), n_checked, n_matches);
    if (errors == 0 && match_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("Mismatches: %0d, results still expected: %0d", errors, match_q.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire

### sim.f
src/mpsm_pkg.sv
src/mpsm_ram.sv
src/mpsm_front.sv
src/mpsm_engine.sv
src/multi_pattern_string_matcher_core.sv
test/testbench.sv
